// ===== hdl/code_byte_pattern_scanner_unit_defines.svh =====
// assertion macros for the code byte pattern scanner
`ifndef CODE_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH
`define CODE_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CBPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cbps_pkg.sv =====
// shared constants and types of the code byte pattern scanner
`default_nettype none
package cbps_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int PAT_REG_BYTES = 16;
    localparam int LEN_W         = 5;
    localparam int MODE_W        = 2;
    localparam int ADDR_W        = 48;
    localparam int SEG_W         = 8;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int PAT_IDX_W     = $clog2(PAT_REG_BYTES);

    // effective length cap: the smaller of the register size and the window
    localparam int EFF_CAP = (MAX_PATTERN < PAT_REG_BYTES) ? MAX_PATTERN : PAT_REG_BYTES;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_PATTERN_LEN  = 3'd2,
        REG_SCAN_MODE    = 3'd3,
        REG_FILE_BASE    = 3'd4,
        REG_VADDR_BASE   = 3'd5,
        REG_SEGMENT_NUM  = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        KIND_PATTERN = 1'b0,
        KIND_XRSTOR  = 1'b1
    } match_kind_t;

    localparam logic [63:0]        RST_PATTERN_LOW = 64'h0000_0000_00EF_010F;
    localparam logic [LEN_W-1:0]   RST_PATTERN_LEN = 5'd3;
    localparam logic [MODE_W-1:0]  RST_SCAN_MODE   = 2'd3;

    localparam int MODE_PATTERN_BIT = 0;
    localparam int MODE_XRSTOR_BIT  = 1;

    // xrstor encoding: 0F AE /5 with a memory operand
    localparam logic [7:0] XR_OP0     = 8'h0F;
    localparam logic [7:0] XR_OP1     = 8'hAE;
    localparam logic [7:0] MODRM_MOD  = 8'hC0;
    localparam logic [7:0] MODRM_REG  = 8'h38;
    localparam logic [7:0] MODRM_XRST = 8'h28;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/cbps_if.sv =====
// request channel interfaces of the code byte pattern scanner
`default_nettype none
interface cbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       segment_end;

    modport source (output valid, output code_byte, output segment_end, input ready);
    modport sink   (input valid, input code_byte, input segment_end, output ready);
endinterface

interface cbps_out_if;
    logic                            valid;
    logic                            ready;
    logic                            match_kind;
    logic [cbps_pkg::SEG_W-1:0]      seg_index;
    logic [cbps_pkg::ADDR_W-1:0]     file_offset;
    logic [cbps_pkg::ADDR_W-1:0]     vm_address;
    logic [cbps_pkg::ADDR_W-1:0]     seg_offset;
    logic                            last_result;

    modport source (output valid, output match_kind, output seg_index, output file_offset,
                    output vm_address, output seg_offset, output last_result, input ready);
    modport sink   (input valid, input match_kind, input seg_index, input file_offset,
                    input vm_address, input seg_offset, input last_result, output ready);
endinterface
`default_nettype wire

// ===== hdl/code_byte_pattern_scanner_unit.sv =====
// top level of the code byte pattern scanner: cell chain, hit stage and output register
//
// code_in carries one code byte per request plus segment_end on a segment's last byte.
// match_out carries one report per request: kind, segment number, file offset, virtual
// address, segment offset and last_result on the final report of a byte.
// cfg_we/cfg_index/cfg_data write the seven setup registers; write only while idle.
// a byte enters the cell chain on acceptance; each cell compares the byte landing in it
// with its pattern byte in the same cycle, so the hits are known at the accepting edge
// and registered in the hit stage.
// a report passes from the hit stage through the output register to match_out.
// throughput: one byte per cycle while each byte gives at most one report and match_out
// does not stall; a byte that gives both reports holds the input until its second report
// is loaded, since the output register moves one report per cycle.
// when match_out stalls, the output register holds and the hit stage keeps its hits;
// code_in drops ready once the hit stage has work that cannot drain this cycle.
// reset empties the window, clears the segment offset and the pending reports, and
// loads the register defaults (pattern 0F 01 EF, length 3, both searches on).
// after segment_end the window and the offset clear, so no match spans two segments.
`default_nettype none
module code_byte_pattern_scanner_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    cbps_in_if.sink                                  code_in,
    cbps_out_if.source                               match_out,
    input  wire logic                                cfg_we,
    input  wire logic [cbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NCELL = cbps_pkg::MAX_PATTERN;
    localparam int AW    = cbps_pkg::ADDR_W;
    localparam int LW    = cbps_pkg::LEN_W;

    // setup registers
    logic [63:0]                    pat_low_reg;
    logic [63:0]                    pat_high_reg;
    logic [LW-1:0]                  pat_len_reg;
    logic [cbps_pkg::MODE_W-1:0]    scan_mode_reg;
    logic [AW-1:0]                  file_base_reg;
    logic [AW-1:0]                  vaddr_base_reg;
    logic [cbps_pkg::SEG_W-1:0]     seg_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg    <= cbps_pkg::RST_PATTERN_LOW;
            pat_high_reg   <= '0;
            pat_len_reg    <= cbps_pkg::RST_PATTERN_LEN;
            scan_mode_reg  <= cbps_pkg::RST_SCAN_MODE;
            file_base_reg  <= '0;
            vaddr_base_reg <= '0;
            seg_num_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cbps_pkg::cfg_reg_t'(cfg_index))
                cbps_pkg::REG_PATTERN_LOW:  pat_low_reg    <= cfg_data;
                cbps_pkg::REG_PATTERN_HIGH: pat_high_reg   <= cfg_data;
                cbps_pkg::REG_PATTERN_LEN:  pat_len_reg    <= cfg_data[LW-1:0];
                cbps_pkg::REG_SCAN_MODE:    scan_mode_reg  <= cfg_data[cbps_pkg::MODE_W-1:0];
                cbps_pkg::REG_FILE_BASE:    file_base_reg  <= cfg_data[AW-1:0];
                cbps_pkg::REG_VADDR_BASE:   vaddr_base_reg <= cfg_data[AW-1:0];
                cbps_pkg::REG_SEGMENT_NUM:  seg_num_reg    <= cfg_data[cbps_pkg::SEG_W-1:0];
                default:                    ;  // index beyond the list is ignored
            endcase
        end
    end

    // effective pattern length, capped at register size and window depth
    logic [LW-1:0] eff_len;
    always_comb
    begin
        eff_len = pat_len_reg;
        if (pat_len_reg > LW'(cbps_pkg::EFF_CAP))
        begin
            eff_len = LW'(cbps_pkg::EFF_CAP);
        end
    end

    // pattern bytes, byte 0 in the low bits of pattern_low
    logic [8*cbps_pkg::PAT_REG_BYTES-1:0] pat_all;
    logic [7:0] pat_bytes [cbps_pkg::PAT_REG_BYTES];
    assign pat_all = {pat_high_reg, pat_low_reg};
    always_comb
    begin
        for (int k = 0; k < cbps_pkg::PAT_REG_BYTES; k++)
        begin
            pat_bytes[k] = pat_all[8*k +: 8];
        end
    end

    // handshake
    logic in_fire;
    assign in_fire = code_in.valid && code_in.ready;

    cbps_pkg::cell_ctrl_t cell_ctrl;
    assign cell_ctrl.shift = in_fire;
    assign cell_ctrl.clear = code_in.segment_end;

    // chain of window cells, cell 0 holds the newest byte
    logic [7:0]       win_byte  [NCELL];
    logic [NCELL-1:0] win_valid;
    logic [NCELL-1:0] cell_ok;

    for (genvar j = 0; j < NCELL; j++)
    begin : g_cell
        logic [7:0]    byte_in;
        logic          valid_in;
        logic          in_range;
        logic [LW-1:0] pat_idx;

        if (j == 0)
        begin : g_head
            assign byte_in  = code_in.code_byte;
            assign valid_in = 1'b1;
        end
        else
        begin : g_body
            assign byte_in  = win_byte[j-1];
            assign valid_in = win_valid[j-1];
        end

        // window position j pairs with pattern byte len-1-j
        assign in_range = (j < cbps_pkg::PAT_REG_BYTES) && (LW'(j) < eff_len);
        assign pat_idx  = LW'(eff_len - LW'(j + 1));

        cbps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .byte_in   (byte_in),
            .valid_in  (valid_in),
            .pat_byte  (pat_bytes[pat_idx[cbps_pkg::PAT_IDX_W-1:0]]),
            .in_range  (in_range),
            .byte_out  (win_byte[j]),
            .valid_out (win_valid[j]),
            .ok        (cell_ok[j])
        );
    end

    // hits for the byte now being accepted
    logic pat_hit;
    logic xr_hit;
    logic [7:0] modrm;
    assign modrm   = code_in.code_byte;
    assign pat_hit = scan_mode_reg[cbps_pkg::MODE_PATTERN_BIT] && (eff_len != '0) && (&cell_ok);
    assign xr_hit  = scan_mode_reg[cbps_pkg::MODE_XRSTOR_BIT] && win_valid[1]
                     && (win_byte[1] == cbps_pkg::XR_OP0)
                     && (win_byte[0] == cbps_pkg::XR_OP1)
                     && ((modrm & cbps_pkg::MODRM_MOD) != cbps_pkg::MODRM_MOD)
                     && ((modrm & cbps_pkg::MODRM_REG) == cbps_pkg::MODRM_XRST);

    // segment offset of the incoming byte
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    always_comb
    begin
        pos_next = pos_reg;
        if (in_fire)
        begin
            pos_next = code_in.segment_end ? '0 : pos_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // hit stage: up to two pending reports of one byte
    logic          hit_pat_reg;
    logic          hit_pat_next;
    logic          hit_xr_reg;
    logic          hit_xr_next;
    logic [AW-1:0] pat_start_reg;
    logic [AW-1:0] xr_start_reg;

    logic out_valid_reg;
    logic out_valid_next;
    logic hit_busy;
    logic out_load;
    logic sel_pat;
    logic sel_last;

    assign hit_busy = hit_pat_reg || hit_xr_reg;
    assign out_load = hit_busy && (!out_valid_reg || match_out.ready);
    assign sel_pat  = hit_pat_reg;                   // pattern report goes first
    assign sel_last = !(hit_pat_reg && hit_xr_reg);

    assign code_in.ready = !hit_busy || (out_load && sel_last);

    always_comb
    begin
        hit_pat_next = hit_pat_reg;
        hit_xr_next  = hit_xr_reg;
        if (in_fire)
        begin
            hit_pat_next = pat_hit;
            hit_xr_next  = xr_hit;
        end
        else if (out_load)
        begin
            if (sel_pat)
            begin
                hit_pat_next = 1'b0;
            end
            else
            begin
                hit_xr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_pat_reg <= 1'b0;
            hit_xr_reg  <= 1'b0;
        end
        else
        begin
            hit_pat_reg <= hit_pat_next;
            hit_xr_reg  <= hit_xr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pat_start_reg <= pos_reg - (AW'(eff_len) - AW'(1));
            xr_start_reg  <= pos_reg - AW'(2);
        end
    end

    // output register
    logic                           out_kind_reg;
    logic [cbps_pkg::SEG_W-1:0]     out_seg_reg;
    logic [AW-1:0]                  out_file_reg;
    logic [AW-1:0]                  out_vaddr_reg;
    logic [AW-1:0]                  out_off_reg;
    logic                           out_last_reg;
    logic [AW-1:0]                  sel_start;

    assign sel_start = sel_pat ? pat_start_reg : xr_start_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (match_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg  <= sel_pat ? cbps_pkg::KIND_PATTERN : cbps_pkg::KIND_XRSTOR;
            out_seg_reg   <= seg_num_reg;
            out_file_reg  <= file_base_reg + sel_start;
            out_vaddr_reg <= vaddr_base_reg + sel_start;
            out_off_reg   <= sel_start;
            out_last_reg  <= sel_last;
        end
    end

    assign match_out.valid       = out_valid_reg;
    assign match_out.match_kind  = out_kind_reg;
    assign match_out.seg_index   = out_seg_reg;
    assign match_out.file_offset = out_file_reg;
    assign match_out.vm_address  = out_vaddr_reg;
    assign match_out.seg_offset  = out_off_reg;
    assign match_out.last_result = out_last_reg;

endmodule
`default_nettype wire

// ===== hdl/cbps_cell.sv =====
// one window cell: holds a byte and its valid flag, compares against a pattern byte
`default_nettype none
module cbps_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cbps_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]           byte_in,
    input  wire logic                 valid_in,
    input  wire logic [7:0]           pat_byte,
    input  wire logic                 in_range,
    output logic [7:0]                byte_out,
    output logic                      valid_out,
    output logic                      ok
);

    logic [7:0] byte_reg;
    logic       valid_reg;
    logic       valid_next;

    // checked against the byte that lands here on this shift
    assign ok = !in_range || (valid_in && (byte_in == pat_byte));

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            valid_next = ctrl.clear ? 1'b0 : valid_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule
`default_nettype wire

// ===== hdl/cbps_checker.sv =====
// port-level checks of the code byte pattern scanner and their binding
`default_nettype none
`include "code_byte_pattern_scanner_unit_defines.svh"
module cbps_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          out_kind,
    input wire logic [cbps_pkg::ADDR_W-1:0]   out_seg_offset,
    input wire logic [cbps_pkg::ADDR_W-1:0]   out_file_offset,
    input wire logic                          out_last
);

    // a stalled report keeps its fields
    `CBPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_seg_offset) && $stable(out_file_offset) && $stable(out_kind) && $stable(out_last), "stalled report changed")

    // a report is withdrawn only once taken
    `CBPS_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(out_ready), "report dropped before taken")

    // only a pattern report can precede another report of the same byte
    `CBPS_ASSERT_NOW(a_kind_order, out_valid && !out_last, out_kind == cbps_pkg::KIND_PATTERN, "xrstor report not last of its byte")

    // the report following a non-final one is the xrstor report of that byte
    `CBPS_ASSERT_NEXT(a_pair_follow, out_valid && out_ready && !out_last, out_valid && out_last && out_kind == cbps_pkg::KIND_XRSTOR, "second report of a byte missing")

endmodule

bind code_byte_pattern_scanner_unit cbps_checker u_cbps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (match_out.valid),
    .out_ready       (match_out.ready),
    .out_kind        (match_out.match_kind),
    .out_seg_offset  (match_out.seg_offset),
    .out_file_offset (match_out.file_offset),
    .out_last        (match_out.last_result)
);
`default_nettype wire
